// File: hw/rtl/affine_matrix_inverse_defines.svh
// Assertion macros shared by the affine matrix inverse RTL.
`ifndef AFFINE_MATRIX_INVERSE_DEFINES_SVH
`define AFFINE_MATRIX_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS

`define AMI_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define AMI_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define AMI_ASSERT_IMP(name, clk_i, rstn_i, ante, cons)

`define AMI_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons)

`endif

`endif

// File: hw/rtl/ami_pkg.sv
// Types, widths and index tables for the affine matrix inverse.
package ami_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int THR_W      = DATA_WIDTH - 1;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int MINOR_W    = PROD_W + 1;
    localparam int HALF_W     = MINOR_W - DATA_WIDTH;
    localparam int PART_W     = HALF_W + DATA_WIDTH;
    localparam int SUM_W      = MINOR_W + DATA_WIDTH + 2;
    localparam int NUM_W      = SUM_W + FRAC_BITS + 2;
    localparam int DEN_W      = SUM_W + 1;
    localparam int DIV_ST     = DATA_WIDTH + 1;

    localparam int N_IN    = 12;
    localparam int N_MINOR = 12;
    localparam int N_TERM  = 12;
    localparam int N_SUM   = 4;
    localparam int N_COF   = 9;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [MINOR_W-1:0]    minor_t;
    typedef logic signed [PART_W-1:0]     part_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic [SUM_W-1:0]             mag_t;
    typedef logic [NUM_W-1:0]             num_t;
    typedef logic [DEN_W-1:0]             den_t;
    typedef logic [DATA_WIDTH-1:0]        quo_t;

    localparam data_t FIX_ONE = data_t'(64'(1) << FRAC_BITS);

    // 2x2 minor k is MUL_A[2k]*MUL_B[2k] - MUL_A[2k+1]*MUL_B[2k+1], entries r*4+c.
    // Minor order: A0 A1 A3 A2 A4 A5, then cofactors 0 1 3 4 6 7.
    localparam int unsigned MUL_A [2*N_MINOR] = '{0, 1, 0, 2, 1, 2, 0, 3, 1, 3, 2, 3,
                                                  5, 6, 2, 1, 6, 4, 0, 2, 4, 5, 1, 0};
    localparam int unsigned MUL_B [2*N_MINOR] = '{5, 4, 6, 4, 6, 5, 7, 4, 7, 5, 7, 6,
                                                  10, 9, 9, 10, 8, 10, 10, 8, 9, 8, 8, 9};

    // Row-2 products: minor index and row-2 column, three terms per sum.
    // Sums: det, tr0, tr1, tr2.
    localparam int unsigned TERM_MINOR [N_TERM] = '{0, 1, 2, 4, 5, 2, 5, 3, 1, 3, 4, 0};
    localparam int unsigned TERM_COL   [N_TERM] = '{2, 1, 0, 2, 1, 3, 0, 2, 3, 1, 0, 3};
    localparam bit          SUM_PLUS   [N_SUM]  = '{1'b1, 1'b0, 1'b1, 1'b0};

    // Transposed cofactors in row-major order of the inverse.
    localparam int unsigned COF_SRC [N_COF] = '{6, 7, 2, 8, 9, 1, 10, 11, 0};
    localparam bit          COF_NEG [N_COF] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                                1'b0, 1'b0, 1'b0};

endpackage

// File: hw/rtl/ami_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ami_divider (
    input  logic          clk,
    input  logic          en,
    input  ami_pkg::num_t num,
    input  ami_pkg::den_t den,
    input  logic          neg,
    output ami_pkg::quo_t quo,
    output logic          ovf,
    output logic          neg_out
);
    import ami_pkg::*;

    localparam int HI_W = NUM_W - DATA_WIDTH;

    den_t rem_reg [DIV_ST];
    den_t den_reg [DIV_ST];
    quo_t low_reg [DIV_ST];
    quo_t quo_reg [DIV_ST];
    logic ovf_reg [DIV_ST];
    logic neg_reg [DIV_ST];

    logic [HI_W-1:0] num_hi;
    assign num_hi = num[NUM_W-1:DATA_WIDTH];

    // Quotient of at least 2^DATA_WIDTH saturates; flag it up front.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(num_hi);
            den_reg[0] <= den;
            low_reg[0] <= num[DATA_WIDTH-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= DEN_W'(num_hi) >= den;
            neg_reg[0] <= neg;
        end
    end

    for (genvar j = 1; j < DIV_ST; j++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[j-1], low_reg[j-1][DATA_WIDTH-1]};
            diff  = trial - {1'b0, den_reg[j-1]};
            ge    = trial >= {1'b0, den_reg[j-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[j] <= den_reg[j-1];
                low_reg[j] <= {low_reg[j-1][DATA_WIDTH-2:0], 1'b0};
                quo_reg[j] <= {quo_reg[j-1][DATA_WIDTH-2:0], ge};
                ovf_reg[j] <= ovf_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    assign quo     = quo_reg[DIV_ST-1];
    assign ovf     = ovf_reg[DIV_ST-1];
    assign neg_out = neg_reg[DIV_ST-1];

endmodule

// File: hw/rtl/affine_matrix_inverse.sv
// Top level: pipelined 3x4 affine matrix inverse in signed fixed point.
// An input transaction passes through 40 pipeline stages and the output register
//   to out_valid (the first stage loads on the accepting edge).
// Throughput: one transaction per cycle while the skid entry is empty; depth is set
//   by the divider array, one quotient bit per stage for each of the twelve outputs.
// Reset clears all valid bits and the skid stage and loads thr_reg with 1.
`include "affine_matrix_inverse_defines.svh"

module affine_matrix_inverse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ami_pkg::data_t                in_r0c0,
    input  ami_pkg::data_t                in_r0c1,
    input  ami_pkg::data_t                in_r0c2,
    input  ami_pkg::data_t                in_r0c3,
    input  ami_pkg::data_t                in_r1c0,
    input  ami_pkg::data_t                in_r1c1,
    input  ami_pkg::data_t                in_r1c2,
    input  ami_pkg::data_t                in_r1c3,
    input  ami_pkg::data_t                in_r2c0,
    input  ami_pkg::data_t                in_r2c1,
    input  ami_pkg::data_t                in_r2c2,
    input  ami_pkg::data_t                in_r2c3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ami_pkg::data_t                out_r0c0,
    output ami_pkg::data_t                out_r0c1,
    output ami_pkg::data_t                out_r0c2,
    output ami_pkg::data_t                out_r0c3,
    output ami_pkg::data_t                out_r1c0,
    output ami_pkg::data_t                out_r1c1,
    output ami_pkg::data_t                out_r1c2,
    output ami_pkg::data_t                out_r1c3,
    output ami_pkg::data_t                out_r2c0,
    output ami_pkg::data_t                out_r2c1,
    output ami_pkg::data_t                out_r2c2,
    output ami_pkg::data_t                out_r2c3,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ami_pkg::THR_W-1:0]     cfg_data
);
    import ami_pkg::*;

    localparam int PIPE_ST = 7 + DIV_ST;
    localparam int SING_ST = DIV_ST + 2;
    localparam logic [DATA_WIDTH:0] LIM_POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH:0] LIM_NEG = {2'b01, {(DATA_WIDTH-1){1'b0}}};

    logic [THR_W-1:0]   thr_reg;
    logic [PIPE_ST-1:0] valid_reg;
    logic [SING_ST-1:0] sing_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               en;
    logic               push;
    logic               pop;

    data_t  m_in [N_IN];
    prod_t  prod_reg [2*N_MINOR];
    data_t  row2_s1_reg [4];
    data_t  row2_s2_reg [4];
    minor_t minor_reg [N_MINOR];
    part_t  part_lo_reg [N_TERM];
    part_t  part_hi_reg [N_TERM];
    minor_t cof_s3_reg [N_COF];
    minor_t cof_s4_reg [N_COF];
    minor_t cof_s5_reg [N_COF];
    sum_t   term_reg [N_TERM];
    sum_t   sum_reg [N_SUM];
    mag_t   dmag_reg;
    num_t   nmag_reg [N_IN];
    logic   neg_s6_reg [N_IN];
    num_t   num_reg [N_IN];
    den_t   den_s7_reg;
    logic   neg_s7_reg [N_IN];
    quo_t   quo [N_IN];
    logic   ovf [N_IN];
    logic   neg_q [N_IN];
    data_t  res [N_IN];
    data_t  out_reg [N_IN];
    data_t  skid_reg [N_IN];

    sum_t   det;
    mag_t   det_mag;
    logic   det_sing;

    assign en        = !skid_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign push      = en && valid_reg[PIPE_ST-1];
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;

    assign m_in[0]  = in_r0c0;
    assign m_in[1]  = in_r0c1;
    assign m_in[2]  = in_r0c2;
    assign m_in[3]  = in_r0c3;
    assign m_in[4]  = in_r1c0;
    assign m_in[5]  = in_r1c1;
    assign m_in[6]  = in_r1c2;
    assign m_in[7]  = in_r1c3;
    assign m_in[8]  = in_r2c0;
    assign m_in[9]  = in_r2c1;
    assign m_in[10] = in_r2c2;
    assign m_in[11] = in_r2c3;

    // Stage 1: pairwise products of the top two rows and row 2
    for (genvar k = 0; k < 2*N_MINOR; k++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[k] <= m_in[MUL_A[k]] * m_in[MUL_B[k]];
            end
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_row2
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row2_s1_reg[c] <= m_in[8+c];
                row2_s2_reg[c] <= row2_s1_reg[c];
            end
        end
    end

    // Stage 2: 2x2 minors
    for (genvar k = 0; k < N_MINOR; k++)
    begin : g_minor
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                minor_reg[k] <= MINOR_W'(prod_reg[2*k]) - MINOR_W'(prod_reg[2*k+1]);
            end
        end
    end

    // Stage 3: minor times row-2 entry, split into two narrow partial products
    for (genvar t = 0; t < N_TERM; t++)
    begin : g_part
        logic signed [HALF_W-1:0] lo_op;
        logic signed [HALF_W-1:0] hi_op;

        assign lo_op = {1'b0, minor_reg[TERM_MINOR[t]][DATA_WIDTH-1:0]};
        assign hi_op = minor_reg[TERM_MINOR[t]][MINOR_W-1:DATA_WIDTH];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                part_lo_reg[t] <= lo_op * row2_s2_reg[TERM_COL[t]];
                part_hi_reg[t] <= hi_op * row2_s2_reg[TERM_COL[t]];
            end
        end
    end

    for (genvar i = 0; i < N_COF; i++)
    begin : g_cof
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (COF_NEG[i])
                begin
                    cof_s3_reg[i] <= -minor_reg[COF_SRC[i]];
                end
                else
                begin
                    cof_s3_reg[i] <= minor_reg[COF_SRC[i]];
                end
                cof_s4_reg[i] <= cof_s3_reg[i];
                cof_s5_reg[i] <= cof_s4_reg[i];
            end
        end
    end

    // Stage 4: merge partial products
    for (genvar t = 0; t < N_TERM; t++)
    begin : g_term
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[t] <= (SUM_W'(part_hi_reg[t]) <<< DATA_WIDTH) + SUM_W'(part_lo_reg[t]);
            end
        end
    end

    // Stage 5: determinant and the three translation numerators
    for (genvar s = 0; s < N_SUM; s++)
    begin : g_sum
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (SUM_PLUS[s])
                begin
                    sum_reg[s] <= term_reg[3*s] - term_reg[3*s+1] + term_reg[3*s+2];
                end
                else
                begin
                    sum_reg[s] <= term_reg[3*s] - term_reg[3*s+1] - term_reg[3*s+2];
                end
            end
        end
    end

    // Stage 6: magnitudes, signs and the singular test
    always_comb
    begin
        det      = sum_reg[0];
        det_mag  = det[SUM_W-1] ? mag_t'(-det) : mag_t'(det);
        det_sing = (det == '0) ||
                   (det_mag < SUM_W'({thr_reg, {(2*FRAC_BITS){1'b0}}}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg   <= det_mag;
            den_s7_reg <= {dmag_reg, 1'b0};
        end
    end

    for (genvar ch = 0; ch < N_IN; ch++)
    begin : g_num
        logic sgn;
        mag_t mag;

        if (ch % 4 == 3)
        begin : g_tr
            assign sgn = sum_reg[1 + ch/4][SUM_W-1];
            assign mag = sgn ? mag_t'(-sum_reg[1 + ch/4]) : mag_t'(sum_reg[1 + ch/4]);
        end
        else
        begin : g_cf
            assign sgn = cof_s5_reg[(ch/4)*3 + ch%4][MINOR_W-1];
            assign mag = sgn ? mag_t'(-SUM_W'(cof_s5_reg[(ch/4)*3 + ch%4]))
                             : mag_t'(SUM_W'(cof_s5_reg[(ch/4)*3 + ch%4]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ch % 4 == 3)
                begin
                    nmag_reg[ch] <= NUM_W'(mag) << FRAC_BITS;
                end
                else
                begin
                    nmag_reg[ch] <= NUM_W'(mag) << (2*FRAC_BITS);
                end
                neg_s6_reg[ch] <= sgn ^ det[SUM_W-1];
                // Stage 7: round half away from zero as floor((2n + d) / 2d)
                num_reg[ch]    <= (nmag_reg[ch] << 1) + NUM_W'(dmag_reg);
                neg_s7_reg[ch] <= neg_s6_reg[ch];
            end
        end

        ami_divider u_div (
            .clk     (clk),
            .en      (en),
            .num     (num_reg[ch]),
            .den     (den_s7_reg),
            .neg     (neg_s7_reg[ch]),
            .quo     (quo[ch]),
            .ovf     (ovf[ch]),
            .neg_out (neg_q[ch])
        );

        logic [DATA_WIDTH:0] lim;
        logic [DATA_WIDTH:0] qmag;
        logic [DATA_WIDTH:0] sval;

        always_comb
        begin
            lim  = neg_q[ch] ? LIM_NEG : LIM_POS;
            qmag = (ovf[ch] || ({1'b0, quo[ch]} > lim)) ? lim : {1'b0, quo[ch]};
            sval = neg_q[ch] ? -qmag : qmag;
            if (sing_reg[SING_ST-1])
            begin
                res[ch] = (ch % 5 == 0) ? FIX_ONE : '0;
            end
            else
            begin
                res[ch] = sval[DATA_WIDTH-1:0];
            end
        end

        // Output register with one skid entry behind it
        always_ff @(posedge clk)
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_reg[ch] <= skid_reg[ch];
                end
            end
            else if (push)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_reg[ch] <= res[ch];
                end
                else
                begin
                    skid_reg[ch] <= res[ch];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_W'(1);
            valid_reg      <= '0;
            sing_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (en)
            begin
                valid_reg <= {valid_reg[PIPE_ST-2:0], in_valid};
                sing_reg  <= {sing_reg[SING_ST-2:0], det_sing};
            end
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_r0c0 = out_reg[0];
    assign out_r0c1 = out_reg[1];
    assign out_r0c2 = out_reg[2];
    assign out_r0c3 = out_reg[3];
    assign out_r1c0 = out_reg[4];
    assign out_r1c1 = out_reg[5];
    assign out_r1c2 = out_reg[6];
    assign out_r1c3 = out_reg[7];
    assign out_r2c0 = out_reg[8];
    assign out_r2c1 = out_reg[9];
    assign out_r2c2 = out_reg[10];
    assign out_r2c3 = out_reg[11];

    `AMI_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `AMI_ASSERT_IMP(a_skid_blocks_input, clk, rst_n, skid_valid_reg, !in_ready)
    `AMI_ASSERT_NEXT(a_skid_fill, clk, rst_n, push && out_valid_reg && !out_ready, skid_valid_reg)
    `AMI_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg)

endmodule
